// ----- hw/rtl/tdpt_pkg.sv -----
package tdpt_pkg;

    // fixed field widths of the stream words
    localparam int CANDIDATE_W = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;

    // default width of the number datapath (range 8..64)
    localparam int NUM_WIDTH_DEF = 32;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the candidate, reset the divisor to three
        logic div_init;    // start a remainder pass with the current divisor
        logic div_step;    // one restoring step of the remainder unit
        logic d_advance;   // move on to the next odd divisor
    } tdpt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic small_done;  // below two or even: no division needed
        logic small_prime; // the candidate is two
        logic div_last;    // this step finishes the remainder pass
        logic d_over;      // divisor exceeds the quotient, so no factor is left
        logic rem_zero;    // divisor leaves no remainder
    } tdpt_stat_t;

endpackage

// ----- hw/rtl/tdpt_datapath.sv -----
module tdpt_datapath #(
    parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [tdpt_pkg::CANDIDATE_W-1:0]   candidate,
    input  tdpt_pkg::tdpt_cmd_t                cmd,
    output tdpt_pkg::tdpt_stat_t               stat
);
    import tdpt_pkg::*;

    localparam int CNT_W = $clog2(NUM_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WIDTH - 1);

    logic [NUM_WIDTH+CANDIDATE_W-1:0] cand_wide;
    logic [NUM_WIDTH-1:0] n_reg,   n_next;
    logic [NUM_WIDTH-1:0] d_reg,   d_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_WIDTH:0]   shifted;
    logic [NUM_WIDTH+1:0] diff;

    // bits above the datapath width are dropped
    assign cand_wide = {{NUM_WIDTH{1'b0}}, candidate};

    // one restoring division step: bring down the next dividend bit
    assign shifted = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, d_reg};

    always_comb begin
        n_next   = n_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            n_next = cand_wide[NUM_WIDTH-1:0];
            d_next = NUM_WIDTH'(3);
        end
        if (cmd.d_advance) begin
            d_next = d_reg + NUM_WIDTH'(2);
        end
        if (cmd.div_init) begin
            rem_next = '0;
            quo_next = n_reg;
            cnt_next = '0;
        end
        if (cmd.div_step) begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (!diff[NUM_WIDTH+1]) begin
                rem_next = diff[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[NUM_WIDTH-1:0];
                quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign stat.small_done  = (n_reg < NUM_WIDTH'(2)) || !n_reg[0];
    assign stat.small_prime = (n_reg == NUM_WIDTH'(2));
    assign stat.div_last    = (cnt_reg == CNT_LAST);
    assign stat.d_over      = (d_reg > quo_reg);
    assign stat.rem_zero    = (rem_reg == '0);

endmodule

// ----- hw/rtl/tdpt_ctrl.sv -----
module tdpt_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  is_prime,
    output tdpt_pkg::tdpt_cmd_t   cmd,
    input  tdpt_pkg::tdpt_stat_t  stat
);
    import tdpt_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_CLASSIFY = 6'b000010,
        ST_INIT     = 6'b000100,
        ST_DIV      = 6'b001000,
        ST_EVAL     = 6'b010000,
        ST_REPORT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   res_reg, res_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   is_prime_reg, is_prime_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        is_prime_next = is_prime_reg;
        cmd           = '0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (stat.small_done) begin
                    res_next   = stat.small_prime;
                    state_next = ST_REPORT;
                end else begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // divisor past the square root means no factor remains
                if (stat.d_over) begin
                    res_next   = 1'b1;
                    state_next = ST_REPORT;
                end else if (stat.rem_zero) begin
                    res_next   = 1'b0;
                    state_next = ST_REPORT;
                end else begin
                    cmd.d_advance = 1'b1;
                    state_next    = ST_INIT;
                end
            end
            ST_REPORT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    is_prime_next = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign is_prime = is_prime_reg;

endmodule

// ----- hw/rtl/trial_division_prime_test_unit.sv -----
// Trial-division primality test. Each input word carries one unsigned candidate, of which
// the low NUM_WIDTH bits are tested; each output word carries one flag, 1 when the candidate
// is prime. Zero, one and even numbers, two among them, are settled without division. Any
// other candidate is divided by 3, 5, 7 and so on in turn through a bit-serial restoring
// remainder unit; each pass yields quotient and remainder together, and the test stops at
// the first zero remainder or once the divisor exceeds the quotient. One candidate is worked
// on at a time; the finished flag sits in an output register so that the next candidate can
// be taken while it waits.
module trial_division_prime_test_unit #(
    parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tdpt_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] candidate
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tdpt_pkg::M_TDATA_W-1:0]   m_tdata   // [0] is_prime, [7:1] zero
);
    import tdpt_pkg::*;

    tdpt_cmd_t  cmd;
    tdpt_stat_t stat;
    logic       is_prime;

    tdpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .is_prime (is_prime),
        .cmd      (cmd),
        .stat     (stat)
    );

    tdpt_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .candidate (s_tdata[CANDIDATE_W-1:0]),
        .cmd       (cmd),
        .stat      (stat)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, is_prime};

endmodule

// ----- tb/tb_trial_division_prime_test_unit.sv -----
module tb_trial_division_prime_test_unit;

    import tdpt_pkg::*;

    localparam int NUM_WIDTH = NUM_WIDTH_DEF;
    localparam logic [63:0] NUM_MASK = (NUM_WIDTH >= 64) ? ~64'd0 : ((64'd1 << NUM_WIDTH) - 64'd1);
    localparam int RANDOM_ITEMS = 80;
    localparam int HOLD_CYCLES = 2000;
    localparam int STALL_LIMIT = 400000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // [31:0] candidate
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // [0] is_prime, [7:1] zero

    logic [CANDIDATE_W-1:0] candidates_q[$];
    logic                   prime_flags_q[$];
    int                     total_items = 0;
    int                     words_sent = 0;
    int                     flags_seen = 0;
    int                     mismatches = 0;
    int                     hold_left = 0;
    bit                     hold_done = 1'b0;
    int                     stall_cycles = 0;
    logic [M_TDATA_W-1:0]   expected_word;

    trial_division_prime_test_unit #(
        .NUM_WIDTH(NUM_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // trial division with the quotient bound, on the candidate cut to the datapath width
    function automatic logic prime_flag(logic [63:0] raw);
        logic [63:0] n;
        logic [63:0] d;
        n = raw & NUM_MASK;
        if (n < 64'd2)
            return 1'b0;
        if (!n[0])
            return n == 64'd2;
        for (d = 64'd3; d <= n / d; d += 64'd2) begin
            if (n % d == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                prime_flags_q.push_back(prime_flag({32'd0, s_tdata}));
                words_sent <= words_sent + 1;
            end
            // no idling while the middle stretch of words goes in
            if (candidates_q.size() != 0 &&
                ((words_sent >= 45 && words_sent < 75) || $urandom_range(99) >= 38)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= candidates_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                flags_seen <= flags_seen + 1;
                if (prime_flags_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: actual %h", m_tdata);
                end else begin
                    expected_word = '0;
                    expected_word[0] = prime_flags_q.pop_front();
                    if (m_tdata !== expected_word) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("is_prime mismatch on word %0d: expected %h, actual %h",
                                     flags_seen, expected_word, m_tdata);
                    end
                end
            end
            // one long hold-off so that the block fills and stalls its input
            if (hold_left != 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && flags_seen >= 20) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= (flags_seen >= 45 && flags_seen < 75) || $urandom_range(99) >= 38;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("trial_division_prime_test_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] r;
        int          p;
        int          sel;
        int          small_primes[6];
        small_primes = '{2, 3, 5, 7, 11, 13};

        // zero, one, two, smallest odd primes, squares on the bound, other small and full-width cases
        candidates_q.push_back(32'd0);
        candidates_q.push_back(32'd1);
        candidates_q.push_back(32'd2);
        candidates_q.push_back(32'd3);
        candidates_q.push_back(32'd4);
        candidates_q.push_back(32'd16777213);   // slow prime near the top of 24 bits
        candidates_q.push_back(32'd5);
        candidates_q.push_back(32'd7);
        candidates_q.push_back(32'd9);
        candidates_q.push_back(32'd15);
        candidates_q.push_back(32'd25);
        candidates_q.push_back(32'd49);
        candidates_q.push_back(32'd97);
        candidates_q.push_back(32'd1042441);    // 1021 squared
        candidates_q.push_back(32'd65537);
        candidates_q.push_back(32'hFFFF_FFFF);
        candidates_q.push_back(32'hFFFF_FFFE);
        candidates_q.push_back(32'h8000_0000);
        candidates_q.push_back(32'h8000_0001);
        candidates_q.push_back(32'hAAAA_AAAA);
        candidates_q.push_back(32'h5555_5555);

        // mostly small numbers; full-width ones carry a small factor to keep them quick
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                candidates_q.push_back($urandom_range(1023));
            end else if (sel < 80) begin
                candidates_q.push_back($urandom_range(262143));
            end else begin
                r = $urandom;
                p = small_primes[$urandom_range(5)];
                candidates_q.push_back(r - (r % p));
            end
        end
        total_items = candidates_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (words_sent < total_items)
            @(posedge aclk);
        while (prime_flags_q.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        if (mismatches == 0)
            $display("trial_division_prime_test_unit regression: pass");
        else
            $display("trial_division_prime_test_unit regression: fail");
        $finish;
    end

endmodule

// ----- trial_division_prime_test_unit.f -----
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_datapath.sv
hw/rtl/tdpt_ctrl.sv
hw/rtl/trial_division_prime_test_unit.sv
tb/tb_trial_division_prime_test_unit.sv
